// ----- hdl/pifht_pkg.sv -----
// Shared types and constants for the point-in-figure hit test block.
`default_nettype none

package pifht_pkg;

    // Fixed field widths
    localparam int COORD_W   = 24;
    localparam int PN_W      = 16;
    localparam int FIG_NUM_W = 5;

    // Item mode codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    // Figure shape codes
    localparam logic SHAPE_RECT   = 1'b0;
    localparam logic SHAPE_CIRCLE = 1'b1;

    // Input beat
    typedef struct packed {
        logic                       mode;
        logic                       shape_kind;
        logic signed [COORD_W-1:0]  coord_a;
        logic signed [COORD_W-1:0]  coord_b;
        logic signed [COORD_W-1:0]  coord_c;
        logic signed [COORD_W-1:0]  coord_d;
    } item_t;

    // Output beat
    typedef struct packed {
        logic [PN_W-1:0]      point_number;
        logic [FIG_NUM_W-1:0] figure_number;
        logic                 contained;
        logic                 last;
    } result_t;

    // One figure table entry
    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  a;
        logic signed [COORD_W-1:0]  b;
        logic signed [COORD_W-1:0]  c;
        logic signed [COORD_W-1:0]  d;
    } figure_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/pifht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pifht_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/point_in_figure_hit_test.sv -----
// Top level of the point-in-figure hit test block.
//
// Input channel (item_valid / item_stall / item): a beat with mode = load
// appends a rectangle or circle to the figure table; loads past MAX_FIGURES
// are dropped. A load gives no result. A beat with mode = point tests
// (coord_a, coord_b) against every stored figure in load order.
// Output channel (result_valid / result_stall / result): one beat per figure
// that strictly contains the point, or one not-contained beat (figure 0);
// last marks the final beat of a point.
// Timing: the table sits in a RAM read once per figure, one figure per cycle
// while the output is not stalled. A point raises item_stall while it reads
// each figure, issues an end marker and runs the compare stages; the next
// item is accepted once the last beat of the point has been registered.
// A stalled output freezes the walk pipeline; the output register keeps its
// beat until taken, and the next item may be accepted while it waits.
// Reset empties the table, clears the point counter and drops any beat in
// flight; table contents are not cleared.
`default_nettype none

module point_in_figure_hit_test #(
    parameter int MAX_FIGURES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output      logic               item_stall,
    input  wire pifht_pkg::item_t   item,
    output      logic               result_valid,
    input  wire logic               result_stall,
    output      pifht_pkg::result_t result
);

    localparam int CW       = pifht_pkg::COORD_W;
    localparam int IDX_W    = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
    localparam int CNT_W    = $clog2(MAX_FIGURES + 1);
    localparam int FN_EXT_W = (IDX_W + 1 > pifht_pkg::FIG_NUM_W) ?
                              IDX_W + 1 : pifht_pkg::FIG_NUM_W;
    localparam int FIG_W    = $bits(pifht_pkg::figure_t);
    localparam int SQ_W     = 2 * CW + 1;
    localparam int SUM_W    = 2 * CW + 2;

    // Control state
    pifht_pkg::state_t          state_reg, state_next;
    logic [CNT_W-1:0]           fig_count_reg, fig_count_next;
    logic [pifht_pkg::PN_W-1:0] points_seen_reg, points_seen_next;
    logic [CNT_W-1:0]           walk_idx_reg, walk_idx_next;
    logic                       s1_v_reg, s1_v_next;
    logic                       s2_v_reg, s2_v_next;
    logic                       pend_v_reg, pend_v_next;
    logic                       result_valid_reg, result_valid_next;

    // Payload
    logic signed [CW-1:0]       x_reg, y_reg;
    logic                       s1_end_reg;
    logic [IDX_W-1:0]           s1_idx_reg;
    logic                       s2_end_reg;
    logic [IDX_W-1:0]           s2_idx_reg;
    logic                       s2_kind_reg;
    logic                       s2_rect_hit_reg;
    logic                       s2_rpos_reg;
    logic [SQ_W-1:0]            s2_dx2_reg, s2_dy2_reg;
    logic [2*CW-1:0]            s2_rr_reg;
    logic [IDX_W-1:0]           pend_idx_reg;
    pifht_pkg::result_t         result_reg, result_next;

    // Combinational
    logic                       item_acc;
    logic                       adv;
    logic                       issue;
    logic                       issue_end;
    logic                       ram_wr_en;
    logic                       ram_rd_en;
    pifht_pkg::figure_t         fig_wr;
    pifht_pkg::figure_t         fig_rd;
    logic signed [CW:0]         dx, dy;
    logic signed [2*CW+1:0]     dx2, dy2;
    logic signed [2*CW-1:0]     rr;
    logic                       rect_hit;
    logic [SUM_W-1:0]           dist_sum;
    logic                       circ_hit;
    logic                       hit;
    logic                       load_out;
    logic [FN_EXT_W-1:0]        pend_fn;

    assign item_stall   = (state_reg != pifht_pkg::S_IDLE);
    assign item_acc     = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Pipeline moves whenever the output slot is free or being emptied
    assign adv       = !result_valid_reg || !result_stall;
    assign issue     = (state_reg == pifht_pkg::S_WALK);
    assign issue_end = (walk_idx_reg == fig_count_reg);

    // Figure table write on a load that still fits
    assign ram_wr_en = item_acc && (item.mode == pifht_pkg::MODE_LOAD) &&
                       (fig_count_reg < CNT_W'(MAX_FIGURES));
    assign ram_rd_en = adv && issue && !issue_end;

    always_comb
    begin
        fig_wr.kind = item.shape_kind;
        fig_wr.a    = item.coord_a;
        fig_wr.b    = item.coord_b;
        fig_wr.c    = item.coord_c;
        fig_wr.d    = item.coord_d;
    end

    pifht_ram #(
        .DATA_W (FIG_W),
        .DEPTH  (MAX_FIGURES),
        .ADDR_W (IDX_W)
    ) u_fig_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fig_count_reg[IDX_W-1:0]),
        .wr_data (fig_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (walk_idx_reg[IDX_W-1:0]),
        .rd_data (fig_rd)
    );

    // Stage 1 to 2: rectangle compares, differences and squares
    always_comb
    begin
        rect_hit = ($signed(fig_rd.a) < x_reg) && (x_reg < $signed(fig_rd.c)) &&
                   ($signed(fig_rd.d) < y_reg) && (y_reg < $signed(fig_rd.b));
        dx  = $signed({x_reg[CW-1], x_reg}) - $signed({fig_rd.a[CW-1], fig_rd.a});
        dy  = $signed({y_reg[CW-1], y_reg}) - $signed({fig_rd.b[CW-1], fig_rd.b});
        dx2 = dx * dx;
        dy2 = dy * dy;
        rr  = $signed(fig_rd.c) * $signed(fig_rd.c);
    end

    // Stage 2 to 3: distance compare and hit select
    assign dist_sum = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
    assign circ_hit = s2_rpos_reg && (dist_sum < {2'b00, s2_rr_reg});
    assign hit      = (s2_kind_reg == pifht_pkg::SHAPE_CIRCLE) ? circ_hit : s2_rect_hit_reg;

    // A pending hit goes out when the next hit or the end marker arrives
    assign load_out = adv && s2_v_reg && (s2_end_reg || (hit && pend_v_reg));
    assign pend_fn  = FN_EXT_W'(pend_idx_reg) + FN_EXT_W'(1);

    // Control next state
    always_comb
    begin
        state_next        = state_reg;
        fig_count_next    = fig_count_reg;
        points_seen_next  = points_seen_reg;
        walk_idx_next     = walk_idx_reg;
        s1_v_next         = s1_v_reg;
        s2_v_next         = s2_v_reg;
        pend_v_next       = pend_v_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (ram_wr_en)
        begin
            fig_count_next = fig_count_reg + CNT_W'(1);
        end

        case (state_reg)
            pifht_pkg::S_IDLE:
            begin
                if (item_acc && (item.mode == pifht_pkg::MODE_POINT))
                begin
                    points_seen_next = (points_seen_reg == '1) ?
                                       pifht_pkg::PN_W'(1) :
                                       points_seen_reg + pifht_pkg::PN_W'(1);
                    walk_idx_next    = '0;
                    state_next       = pifht_pkg::S_WALK;
                end
            end
            pifht_pkg::S_WALK:
            begin
                if (adv)
                begin
                    if (issue_end)
                    begin
                        state_next = pifht_pkg::S_DRAIN;
                    end
                    else
                    begin
                        walk_idx_next = walk_idx_reg + CNT_W'(1);
                    end
                end
            end
            pifht_pkg::S_DRAIN:
            begin
                if (adv && s2_v_reg && s2_end_reg)
                begin
                    state_next = pifht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pifht_pkg::S_IDLE;
            end
        endcase

        // Stage valids
        if (adv)
        begin
            s1_v_next = issue;
            s2_v_next = s1_v_reg;
        end

        // Pending hit tracking
        if (adv && s2_v_reg)
        begin
            if (s2_end_reg)
            begin
                pend_v_next = 1'b0;
            end
            else if (hit)
            begin
                pend_v_next = 1'b1;
            end
        end

        // Output register
        if (load_out)
        begin
            result_valid_next          = 1'b1;
            result_next.point_number   = points_seen_reg;
            result_next.figure_number  = (s2_end_reg && !pend_v_reg) ?
                                         '0 : pend_fn[pifht_pkg::FIG_NUM_W-1:0];
            result_next.contained      = s2_end_reg ? pend_v_reg : 1'b1;
            result_next.last           = s2_end_reg;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pifht_pkg::S_IDLE;
            fig_count_reg    <= '0;
            points_seen_reg  <= '0;
            walk_idx_reg     <= '0;
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            pend_v_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fig_count_reg    <= fig_count_next;
            points_seen_reg  <= points_seen_next;
            walk_idx_reg     <= walk_idx_next;
            s1_v_reg         <= s1_v_next;
            s2_v_reg         <= s2_v_next;
            pend_v_reg       <= pend_v_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;

        if (item_acc && (item.mode == pifht_pkg::MODE_POINT))
        begin
            x_reg <= item.coord_a;
            y_reg <= item.coord_b;
        end

        if (adv)
        begin
            s1_end_reg      <= issue_end;
            s1_idx_reg      <= walk_idx_reg[IDX_W-1:0];
            s2_end_reg      <= s1_end_reg;
            s2_idx_reg      <= s1_idx_reg;
            s2_kind_reg     <= fig_rd.kind;
            s2_rect_hit_reg <= rect_hit;
            s2_rpos_reg     <= !fig_rd.c[CW-1] && (fig_rd.c != '0);
            s2_dx2_reg      <= dx2[SQ_W-1:0];
            s2_dy2_reg      <= dy2[SQ_W-1:0];
            s2_rr_reg       <= rr;
        end

        if (adv && s2_v_reg && !s2_end_reg && hit)
        begin
            pend_idx_reg <= s2_idx_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pifht_checker.sv -----
// Port-level checks for the point-in-figure hit test block, bound to the top level.
`default_nettype none

module pifht_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire pifht_pkg::item_t   item,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire pifht_pkg::result_t result
);

    // A stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // A not-contained beat is the only beat of its point and names no figure
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.contained |->
            result.last && (result.figure_number == '0))
        else $error("malformed not-contained beat");

    // A point beat blocks the input while the table is walked
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.mode == pifht_pkg::MODE_POINT) |=> item_stall)
        else $error("input not held during walk");

    // A load beat leaves the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.mode == pifht_pkg::MODE_LOAD) |=> !item_stall)
        else $error("load held the input");

    // Beats of one point carry the same point number
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=>
            !result_valid || (result.point_number == $past(result.point_number)))
        else $error("point number changed inside a point");

endmodule

bind point_in_figure_hit_test pifht_checker u_pifht_checker (.*);

`default_nettype wire

// ----- test/tb_point_in_figure_hit_test.sv -----
// Self-checking testbench for the point-in-figure hit test block.
`timescale 1ns / 1ps

module tb_point_in_figure_hit_test;

    localparam int FIG_SLOTS       = 16;
    localparam int CW              = pifht_pkg::COORD_W;
    localparam int PNW             = pifht_pkg::PN_W;
    localparam int FNW             = pifht_pkg::FIG_NUM_W;
    localparam int CMAX            = 8388607;
    localparam int CMIN            = -8388608;
    localparam int RANDOM_ITEMS    = 300;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int TAIL_CYCLES     = 40;

    typedef enum logic [1:0] {
        STALL_OFF,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_style_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    pifht_pkg::item_t   item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    pifht_pkg::result_t result;

    // Predictor state
    pifht_pkg::figure_t fig_table [FIG_SLOTS];
    int unsigned        fig_count = 0;
    logic [15:0]        point_seq = '0;
    pifht_pkg::result_t hits_due [$];

    // Pacing state
    bit           sender_bursty = 1'b0;
    int           burst_left    = 0;
    stall_style_t stall_style   = STALL_OFF;
    logic [15:0]  stall_pat     = '0;
    int           mismatches    = 0;

    // Directed table
    pifht_pkg::item_t   plan_beat  [$];
    bit                 plan_typed [$];
    pifht_pkg::result_t plan_want  [$];

    point_in_figure_hit_test #(
        .MAX_FIGURES(FIG_SLOTS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    function automatic pifht_pkg::item_t beat(logic m, logic k, int a, int b, int c, int d);
        pifht_pkg::item_t it;
        it.mode       = m;
        it.shape_kind = k;
        it.coord_a    = CW'(a);
        it.coord_b    = CW'(b);
        it.coord_c    = CW'(c);
        it.coord_d    = CW'(d);
        return it;
    endfunction

    function automatic pifht_pkg::result_t miss(int pn);
        pifht_pkg::result_t r;
        r.point_number  = PNW'(pn);
        r.figure_number = '0;
        r.contained     = 1'b0;
        r.last          = 1'b1;
        return r;
    endfunction

    // Strict containment; circle uses squared distance, exact in 64 bits
    function automatic bit hits(pifht_pkg::figure_t f, longint x, longint y);
        longint a, b, c, d;
        a = longint'(f.a);
        b = longint'(f.b);
        c = longint'(f.c);
        d = longint'(f.d);
        if (f.kind == pifht_pkg::SHAPE_RECT)
            return (a < x) && (x < c) && (d < y) && (y < b);
        if (c <= 0)
            return 1'b0;
        return (x - a) * (x - a) + (y - b) * (y - b) < c * c;
    endfunction

    // Apply one accepted beat to the predictor; queue its results if keep is set
    function automatic void predict(pifht_pkg::item_t it, bit keep);
        pifht_pkg::result_t pend;
        bit                 have;
        longint             x, y;
        have = 1'b0;
        if (it.mode == pifht_pkg::MODE_LOAD)
        begin
            if (fig_count < FIG_SLOTS)
            begin
                fig_table[fig_count] = '{it.shape_kind, it.coord_a, it.coord_b,
                                         it.coord_c, it.coord_d};
                fig_count++;
            end
            return;
        end
        point_seq = (point_seq == 16'hFFFF) ? 16'd1 : point_seq + 16'd1;
        x = longint'(it.coord_a);
        y = longint'(it.coord_b);
        for (int i = 0; i < fig_count; i++)
        begin
            if (hits(fig_table[i], x, y))
            begin
                if (have && keep)
                    hits_due.push_back(pend);
                pend.point_number  = point_seq;
                pend.figure_number = FNW'(i + 1);
                pend.contained     = 1'b1;
                pend.last          = 1'b0;
                have = 1'b1;
            end
        end
        if (!have)
            pend = miss(int'(point_seq));
        else
            pend.last = 1'b1;
        if (keep)
            hits_due.push_back(pend);
    endfunction

    task automatic report(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Drive one beat at the falling edge, with optional idle gap ahead of a burst
    task automatic send_item(pifht_pkg::item_t it, bit typed, pifht_pkg::result_t want);
        int gap;
        @(negedge clk);
        if (sender_bursty && burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 10);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        predict(it, !typed);
        if (typed)
            hits_due.push_back(want);
    endtask

    // Receiver back-pressure
    always @(negedge clk)
    begin
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
        case (stall_style)
            STALL_PATTERN: result_stall <= stall_pat[0];
            STALL_HEAVY:   result_stall <= ($urandom_range(0, 3) != 0);
            default:       result_stall <= 1'b0;
        endcase
    end

    // Result beat check against the oldest expectation
    always @(posedge clk)
    begin : check_results
        pifht_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (hits_due.size() == 0)
            begin
                report($sformatf("unexpected beat pn %0d fig %0d contained %0b last %0b",
                                 result.point_number, result.figure_number,
                                 result.contained, result.last));
            end
            else
            begin
                want = hits_due.pop_front();
                if (result.point_number != want.point_number)
                    report($sformatf("point_number %0d, want %0d",
                                     result.point_number, want.point_number));
                if (result.figure_number != want.figure_number)
                    report($sformatf("pn %0d figure_number %0d, want %0d", want.point_number,
                                     result.figure_number, want.figure_number));
                if (result.contained != want.contained)
                    report($sformatf("pn %0d contained %0b, want %0b", want.point_number,
                                     result.contained, want.contained));
                if (result.last != want.last)
                    report($sformatf("pn %0d last %0b, want %0b", want.point_number,
                                     result.last, want.last));
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_point_in_figure_hit_test: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        pifht_pkg::item_t   it;
        pifht_pkg::result_t none;
        pifht_pkg::figure_t f;
        int                 counted, pick, sel, x, y, cx, cy, hw, hh;
        int                 fa, fb, fc, fd;

        none          = '0;
        sender_bursty = 1'b1;
        stall_style   = STALL_PATTERN;
        stall_pat     = 16'($urandom) & 16'h7FFF;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: empty-table misses right after reset
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT, 0, 0, 0, 0));
        plan_typed.push_back(1'b1);
        plan_want.push_back(miss(1));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_CIRCLE,
                                 CMIN, CMAX, CMIN, CMAX));
        plan_typed.push_back(1'b1);
        plan_want.push_back(miss(2));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT,
                                 CMAX, CMIN, CMAX, CMIN));
        plan_typed.push_back(1'b1);
        plan_want.push_back(miss(3));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_CIRCLE, 5, 5, -1, -1));
        plan_typed.push_back(1'b1);
        plan_want.push_back(miss(4));
        // Figures: full-range rect, circle, swapped rect, zero and negative radius,
        // corner circles of maximum radius, small rect
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_RECT,
                                 CMIN, CMAX, CMAX, CMIN));
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_CIRCLE,
                                 0, 0, 1280, CMIN));
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_RECT,
                                 1000, -1000, -1000, 1000));
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_CIRCLE,
                                 0, 0, 0, CMAX));
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_CIRCLE,
                                 0, 0, -256, 0));
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_CIRCLE,
                                 CMIN, CMIN, CMAX, -1));
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_RECT,
                                 0, 512, 512, 0));
        plan_beat.push_back(beat(pifht_pkg::MODE_LOAD, pifht_pkg::SHAPE_CIRCLE,
                                 CMAX, CMAX, CMAX, 0));
        // Points: inside several, on the circle edge, on rect edges, near corners
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT,
                                 0, 0, CMAX, CMIN));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_CIRCLE,
                                 768, 1024, 0, 0));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT,
                                 CMIN, 0, -1, -1));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT,
                                 256, 256, 0, 0));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_CIRCLE,
                                 CMIN + 1, CMIN + 1, 0, 0));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT,
                                 CMAX - 1, CMAX - 1, 0, 0));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT,
                                 512, 256, 0, 0));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_CIRCLE,
                                 1, 1, CMIN, CMAX));
        plan_beat.push_back(beat(pifht_pkg::MODE_POINT, pifht_pkg::SHAPE_RECT,
                                 0, CMAX, 0, 0));
        while (plan_typed.size() < plan_beat.size())
        begin
            plan_typed.push_back(1'b0);
            plan_want.push_back(none);
        end

        foreach (plan_beat[i])
            send_item(plan_beat[i], plan_typed[i], plan_want[i]);

        // Random part in three pacing phases
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_bursty = (phase != 1);
            stall_style   = (phase == 0) ? STALL_PATTERN :
                            (phase == 1) ? STALL_HEAVY : STALL_OFF;
            stall_pat     = 16'($urandom) & 16'h7FFF;
            counted       = 0;
            while (counted < RANDOM_ITEMS / 3)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 22)
                begin
                    // Load, mostly overlapping the origin; some degenerate
                    cx = int'($urandom_range(0, 2048)) - 1024;
                    cy = int'($urandom_range(0, 2048)) - 1024;
                    it.mode       = pifht_pkg::MODE_LOAD;
                    it.shape_kind = 1'($urandom_range(0, 1));
                    it.coord_d    = CW'($urandom);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        it.coord_a = CW'($urandom);
                        it.coord_b = CW'($urandom);
                        it.coord_c = CW'($urandom);
                    end
                    else if (it.shape_kind == pifht_pkg::SHAPE_RECT)
                    begin
                        hw = $urandom_range(1200, 6000);
                        hh = $urandom_range(1200, 6000);
                        if ($urandom_range(0, 7) == 0)
                            hw = -hw;
                        it.coord_a = CW'(cx - hw);
                        it.coord_c = CW'(cx + hw);
                        it.coord_b = CW'(cy + hh);
                        it.coord_d = CW'(cy - hh);
                    end
                    else
                    begin
                        it.coord_a = CW'(cx);
                        it.coord_b = CW'(cy);
                        it.coord_c = ($urandom_range(0, 7) == 0) ?
                                     CW'(-int'($urandom_range(0, 300))) :
                                     CW'(int'($urandom_range(1600, 6000)));
                    end
                end
                else
                begin
                    // Point: near the cluster, on a stored edge, or anywhere
                    sel = $urandom_range(0, 9);
                    if (sel < 6)
                    begin
                        x = int'($urandom_range(0, 8000)) - 4000;
                        y = int'($urandom_range(0, 8000)) - 4000;
                    end
                    else if (sel < 8 && fig_count > 0)
                    begin
                        f  = fig_table[$urandom_range(0, fig_count - 1)];
                        fa = int'(f.a);
                        fb = int'(f.b);
                        fc = int'(f.c);
                        fd = int'(f.d);
                        if (f.kind == pifht_pkg::SHAPE_RECT)
                        begin
                            x = $urandom_range(0, 1) ? fa : fc;
                            y = (fb + fd) / 2;
                            if ($urandom_range(0, 1))
                            begin
                                x = (fa + fc) / 2;
                                y = $urandom_range(0, 1) ? fb : fd;
                            end
                        end
                        else
                        begin
                            x = fa + fc;
                            y = fb;
                            if ($urandom_range(0, 1))
                            begin
                                x = fa;
                                y = fb - fc;
                            end
                        end
                        x = x + int'($urandom_range(0, 2)) - 1;
                    end
                    else
                    begin
                        x = int'($urandom);
                        y = int'($urandom);
                    end
                    it.mode       = pifht_pkg::MODE_POINT;
                    it.shape_kind = 1'($urandom_range(0, 1));
                    it.coord_a    = CW'(x);
                    it.coord_b    = CW'(y);
                    it.coord_c    = CW'($urandom);
                    it.coord_d    = CW'($urandom);
                end
                counted++;
                send_item(it, 1'b0, none);
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_point_in_figure_hit_test: done, clean");
        else
            $display("tb_point_in_figure_hit_test: done, errors");
        $finish;
    end

endmodule
